// ===== hdl/gpio_bank_with_edge_level_interrupts_macros.svh =====
// Assertion helpers shared by the GPIO bank modules.
`ifndef GPIO_BANK_WITH_EDGE_LEVEL_INTERRUPTS_MACROS_SVH
`define GPIO_BANK_WITH_EDGE_LEVEL_INTERRUPTS_MACROS_SVH

// Check expr in the same cycle as cond.
`define GBEI_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |-> (expr)) else $error("assertion failed");

// Check expr in the cycle after cond.
`define GBEI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |=> (expr)) else $error("assertion failed");

`endif

// ===== hdl/gbei_pkg.sv =====
`default_nettype none

package gbei_pkg;

    localparam int PIN_COUNT = 32;
    localparam int WORD_W    = 32;

    localparam logic [WORD_W-1:0] PIN_MASK = (PIN_COUNT >= WORD_W) ? {WORD_W{1'b1}} :
        WORD_W'((64'd1 << PIN_COUNT) - 64'd1);

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] REG_DATA   = 3'd0;
    localparam logic [2:0] REG_DIR    = 3'd1;
    localparam logic [2:0] REG_ENABLE = 3'd2;
    localparam logic [2:0] REG_SENSE0 = 3'd3;
    localparam logic [2:0] REG_SENSE1 = 3'd4;
    localparam logic [2:0] REG_SENSE2 = 3'd5;
    localparam logic [2:0] REG_STATUS = 3'd6;
    localparam logic [2:0] REG_NONE   = 3'd7;

    typedef struct packed {
        logic [1:0]        command;
        logic [2:0]        reg_index;
        logic [WORD_W-1:0] write_data;
        logic [WORD_W-1:0] pad_levels;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [WORD_W-1:0] pad_drive;
        logic [WORD_W-1:0] pad_output_enable;
        logic              irq;
        logic              access_error;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/gbei_trigger.sv =====
`default_nettype none

module gbei_trigger (
    input  wire logic [gbei_pkg::WORD_W-1:0] i_sense0,
    input  wire logic [gbei_pkg::WORD_W-1:0] i_sense1,
    input  wire logic [gbei_pkg::WORD_W-1:0] i_sense2,
    input  wire logic [gbei_pkg::WORD_W-1:0] i_prev,
    input  wire logic [gbei_pkg::WORD_W-1:0] i_now,
    output logic      [gbei_pkg::WORD_W-1:0] o_hits
);

    logic [gbei_pkg::WORD_W-1:0] rise;
    logic [gbei_pkg::WORD_W-1:0] fall;

    assign rise = ~i_prev & i_now;
    assign fall = i_prev & ~i_now;

    // Per pin code {sense2,sense1,sense0}: fall, rise, low, high, any edge.
    assign o_hits = (~i_sense2 & ~i_sense1 & ~i_sense0 & fall)
                  | (~i_sense2 & ~i_sense1 &  i_sense0 & rise)
                  | (~i_sense2 &  i_sense1 & ~i_sense0 & ~i_now)
                  | (~i_sense2 &  i_sense1 &  i_sense0 & i_now)
                  | ( i_sense2 & (i_prev ^ i_now));

endmodule

`default_nettype wire

// ===== hdl/gbei_regs.sv =====
`default_nettype none

`include "gpio_bank_with_edge_level_interrupts_macros.svh"

module gbei_regs (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire gbei_pkg::t_req   i_req,
    output gbei_pkg::t_result     o_res
);

    logic [gbei_pkg::WORD_W-1:0] r_latch,  n_latch;
    logic [gbei_pkg::WORD_W-1:0] r_dir,    n_dir;
    logic [gbei_pkg::WORD_W-1:0] r_enable, n_enable;
    logic [gbei_pkg::WORD_W-1:0] r_sense0, n_sense0;
    logic [gbei_pkg::WORD_W-1:0] r_sense1, n_sense1;
    logic [gbei_pkg::WORD_W-1:0] r_sense2, n_sense2;
    logic [gbei_pkg::WORD_W-1:0] r_status, n_status;
    logic [gbei_pkg::WORD_W-1:0] r_levels, n_levels;

    logic [gbei_pkg::WORD_W-1:0] wdata;
    logic [gbei_pkg::WORD_W-1:0] pads;
    logic [gbei_pkg::WORD_W-1:0] hits;
    logic [gbei_pkg::WORD_W-1:0] rdata;
    logic                        err;

    assign wdata = i_req.write_data & gbei_pkg::PIN_MASK;
    assign pads  = i_req.pad_levels & gbei_pkg::PIN_MASK;

    gbei_trigger u_trigger (
        .i_sense0 (r_sense0),
        .i_sense1 (r_sense1),
        .i_sense2 (r_sense2),
        .i_prev   (r_levels),
        .i_now    (pads),
        .o_hits   (hits)
    );

    always_comb begin
        n_latch  = r_latch;
        n_dir    = r_dir;
        n_enable = r_enable;
        n_sense0 = r_sense0;
        n_sense1 = r_sense1;
        n_sense2 = r_sense2;
        n_status = r_status;
        n_levels = r_levels;
        rdata    = '0;
        err      = 1'b0;
        if (i_req.command == gbei_pkg::CMD_READ) begin
            unique case (i_req.reg_index)
                gbei_pkg::REG_DATA:   rdata = r_levels;
                gbei_pkg::REG_DIR:    rdata = r_dir;
                gbei_pkg::REG_ENABLE: rdata = r_enable;
                gbei_pkg::REG_SENSE0: rdata = r_sense0;
                gbei_pkg::REG_SENSE1: rdata = r_sense1;
                gbei_pkg::REG_SENSE2: rdata = r_sense2;
                gbei_pkg::REG_STATUS: rdata = r_status;
                default:              err   = 1'b1;
            endcase
        end else if (i_req.command == gbei_pkg::CMD_WRITE) begin
            unique case (i_req.reg_index)
                gbei_pkg::REG_DATA:   n_latch  = wdata;
                gbei_pkg::REG_DIR:    n_dir    = wdata;
                gbei_pkg::REG_ENABLE: n_enable = wdata;
                gbei_pkg::REG_SENSE0: n_sense0 = wdata;
                gbei_pkg::REG_SENSE1: n_sense1 = wdata;
                gbei_pkg::REG_SENSE2: n_sense2 = wdata;
                gbei_pkg::REG_STATUS: n_status = r_status & ~wdata;
                default:              err      = 1'b1;
            endcase
        end else if (i_req.command == gbei_pkg::CMD_TICK) begin
            n_status = r_status | (hits & r_enable & gbei_pkg::PIN_MASK);
            n_levels = pads;
        end
    end

    // Result reflects the state after this request.
    assign o_res.read_data         = rdata & gbei_pkg::PIN_MASK;
    assign o_res.pad_drive         = n_latch & gbei_pkg::PIN_MASK;
    assign o_res.pad_output_enable = n_dir & gbei_pkg::PIN_MASK;
    assign o_res.irq               = |(n_status & gbei_pkg::PIN_MASK);
    assign o_res.access_error      = err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch  <= '0;
            r_dir    <= '0;
            r_enable <= '0;
            r_sense0 <= '0;
            r_sense1 <= '0;
            r_sense2 <= '0;
            r_status <= '0;
            r_levels <= '0;
        end else if (i_fire) begin
            r_latch  <= n_latch;
            r_dir    <= n_dir;
            r_enable <= n_enable;
            r_sense0 <= n_sense0;
            r_sense1 <= n_sense1;
            r_sense2 <= n_sense2;
            r_status <= n_status;
            r_levels <= n_levels;
        end
    end

    // Status bits appear only on enabled pins.
    `GBEI_ASSERT_NEXT(a_status_gated, i_clk, i_rst_n, 1'b1,
        (r_status & ~$past(r_status) & ~$past(r_enable)) == '0)
    // A status write only clears.
    `GBEI_ASSERT_NEXT(a_status_w1c, i_clk, i_rst_n,
        i_fire && i_req.command == gbei_pkg::CMD_WRITE,
        (r_status & ~$past(r_status)) == '0)
    // A read leaves the state untouched.
    `GBEI_ASSERT_NEXT(a_read_stable, i_clk, i_rst_n,
        i_fire && i_req.command == gbei_pkg::CMD_READ,
        $stable(r_status) && $stable(r_levels) && $stable(r_latch) && $stable(r_dir))

endmodule

`default_nettype wire

// ===== hdl/gpio_bank_with_edge_level_interrupts.sv =====
// GPIO bank of 32 pins with edge and level interrupts.
// Input channel (i_in_valid / o_in_ready) carries one request: a bus read,
// a bus write or a pad sample tick. Output channel (o_out_valid /
// i_out_ready) returns exactly one result per request, in order: read data,
// pad drive, pad output enable, irq and an unmapped-access flag, all taken
// after the request has updated the bank.
// A request is held in an input register and applied to the register bank
// once the output register is free; its result is captured in the output
// register at the same edge as the bank update, and o_out_valid then rises.
// One request per cycle is sustained while the receiver keeps i_out_ready
// high.
// When the receiver stalls, the result waits in the output register while
// one more request may sit in the input register; o_in_ready drops only
// when both are full.
// Synchronous reset clears every bank register, the sampled levels and both
// pipeline valid flags.
`default_nettype none

`include "gpio_bank_with_edge_level_interrupts_macros.svh"

module gpio_bank_with_edge_level_interrupts (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_command,
    input  wire logic [2:0]                   i_reg_index,
    input  wire logic [gbei_pkg::WORD_W-1:0]  i_write_data,
    input  wire logic [gbei_pkg::WORD_W-1:0]  i_pad_levels,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [gbei_pkg::WORD_W-1:0]  o_read_data,
    output logic      [gbei_pkg::WORD_W-1:0]  o_pad_drive,
    output logic      [gbei_pkg::WORD_W-1:0]  o_pad_output_enable,
    output logic                              o_irq,
    output logic                              o_access_error
);

    logic              r_in_valid;
    gbei_pkg::t_req    r_req;
    logic              r_out_valid;
    gbei_pkg::t_result r_res;
    gbei_pkg::t_result res;
    logic              advance;
    logic              accept;

    // Move the held request into the bank when the output slot is free.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    gbei_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_req   (r_req),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.command    <= i_command;
            r_req.reg_index  <= i_reg_index;
            r_req.write_data <= i_write_data;
            r_req.pad_levels <= i_pad_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_res.read_data;
    assign o_pad_drive         = r_res.pad_drive;
    assign o_pad_output_enable = r_res.pad_output_enable;
    assign o_irq               = r_res.irq;
    assign o_access_error      = r_res.access_error;

    // An unmapped access never returns data.
    `GBEI_ASSERT_NOW(a_err_no_data, i_clk, i_rst_n, o_out_valid && o_access_error,
        o_read_data == '0)

endmodule

`default_nettype wire
